/* src/ffgp_pkg.sv */
// Package for the first-fit grid placer: shared constants, types and codes.
// Used by ffgp_occ_mem and first_fit_grid_placer_unit; depends on nothing.
package ffgp_pkg;

	localparam int ROWS_DEF     = 128;
	localparam int MAX_COLS_DEF = 16;

	localparam logic [4:0]  COLUMNS_RST     = 5'd4;
	localparam logic [9:0]  GAP_RST         = 10'd0;
	localparam logic [15:0] TOTAL_WIDTH_RST = 16'd0;
	localparam logic [31:0] Y_MAX           = 32'd16777215;

	localparam logic [1:0] REG_COLUMNS     = 2'd0;
	localparam logic [1:0] REG_GAP         = 2'd1;
	localparam logic [1:0] REG_TOTAL_WIDTH = 2'd2;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PREP,
		ST_DIV,
		ST_SCAN,
		ST_MARK,
		ST_CALC,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic rd_en;
		logic wr_en;
		logic clr;
	} mem_ctl_t;

endpackage

/* src/ffgp_occ_mem.sv */
// Occupancy memory of the placer: one row word per grid row, registered read.
// Per-row valid flops make unwritten or cleared rows read as all free.
// Depends on ffgp_pkg for the control struct.
module ffgp_occ_mem #(
	parameter int ROWS     = ffgp_pkg::ROWS_DEF,
	parameter int MAX_COLS = ffgp_pkg::MAX_COLS_DEF,
	parameter int RW       = (ROWS > 1) ? $clog2(ROWS) : 1
) (
	input  logic                clk,
	input  logic                arst_n,
	input  ffgp_pkg::mem_ctl_t  ctl,
	input  logic [RW-1:0]       rd_addr,
	input  logic [RW-1:0]       wr_addr,
	input  logic [MAX_COLS-1:0] wr_data,
	output logic [MAX_COLS-1:0] rd_data
);

	logic [MAX_COLS-1:0] mem [ROWS];
	logic [ROWS-1:0]     valid_q;
	logic [MAX_COLS-1:0] word_s1;
	logic                hit_s1;

	always_ff @(posedge clk) begin
		if (ctl.wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (ctl.rd_en) begin
			word_s1 <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			hit_s1  <= 1'b0;
		end else begin
			if (ctl.clr) begin
				valid_q <= '0;
			end else if (ctl.wr_en) begin
				valid_q[wr_addr] <= 1'b1;
			end
			if (ctl.rd_en) begin
				hit_s1 <= valid_q[rd_addr];
			end
		end
	end

	assign rd_data = hit_s1 ? word_s1 : '0;

endmodule

/* src/ffgp_div.sv */
// Restoring divider for the column width, one quotient bit per cycle.
// Depends on nothing but its parameters.
module ffgp_div #(
	parameter int DW = 16,
	parameter int VW = 5
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [DW-1:0] num,
	input  logic [VW-1:0] den,
	output logic          done,
	output logic [DW-1:0] quo
);

	localparam int KW = $clog2(DW + 1);

	logic [VW-1:0] rem_q;
	logic [DW-1:0] quo_q;
	logic [VW-1:0] den_q;
	logic [KW-1:0] cnt_q;
	logic          run_q;
	logic          done_q;
	logic [VW:0]   trial;
	logic          ge;

	assign trial = {rem_q, quo_q[DW-1]};
	assign ge    = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= KW'(DW);
			end else if (run_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == KW'(1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= num;
			den_q <= den;
		end else if (run_q) begin
			rem_q <= ge ? VW'(trial - {1'b0, den_q}) : trial[VW-1:0];
			quo_q <= {quo_q[DW-2:0], ge};
		end
	end

	assign done = done_q;
	assign quo  = quo_q;

endmodule

/* src/first_fit_grid_placer_unit.sv */
// First-fit grid placer top level: control, row scan, marking and pixel math.
// A request runs through PREP and the divider, a scan of the rows and, on a fit, a marking pass (both
// skipped if row_span exceeds ROWS), then CALC and OUT; one request at a time, taken only when idle.
// The scan reads one occupancy row per cycle from the single read port of the memory.
// Reset restores the register defaults and marks every grid cell free; no clearing pass.
// Results cannot be stalled: done is high for one cycle. Depends on ffgp_pkg, ffgp_div, ffgp_occ_mem.
module first_fit_grid_placer_unit #(
	parameter int ROWS     = ffgp_pkg::ROWS_DEF,
	parameter int MAX_COLS = ffgp_pkg::MAX_COLS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic        first_card,
	input  logic [4:0]  col_span,
	input  logic [7:0]  row_span,
	output logic        done,
	output logic        placed,
	output logic [6:0]  grid_row,
	output logic [3:0]  grid_col,
	output logic [15:0] pos_x,
	output logic [23:0] pos_y,
	output logic [15:0] box_width,
	output logic [23:0] box_height,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	localparam int RW = (ROWS > 1) ? $clog2(ROWS) : 1;
	localparam int SW = $clog2(ROWS + 1);
	localparam int CW = $clog2(MAX_COLS + 1);
	localparam int IW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
	localparam int UW = CW + 10;
	localparam int NW = (UW > 16) ? UW : 16;
	localparam int PW = 17;

	ffgp_pkg::state_t   state_q, state_d;
	ffgp_pkg::mem_ctl_t mctl;

	logic [4:0]  columns_q;
	logic [9:0]  gap_q;
	logic [15:0] tw_q;

	logic [CW-1:0]       cols_q, cs_q, cols_a, cs_a;
	logic [SW-1:0]       rs_q;
	logic [7:0]          rs_a;
	logic                tall_q;
	logic [MAX_COLS-1:0] smask_q, wmask_q;
	logic [UW-1:0]       used_q;
	logic [15:0]         numer;
	logic [NW-1:0]       tw_ext, used_ext;
	logic                div_done;
	logic [15:0]         div_quo;
	logic [PW-1:0]       p_q;

	logic [RW:0]         scan_addr_q;
	logic [RW-1:0]       mk_addr_q;
	logic [SW-1:0]       mk_left_q;
	logic                vld_s1, mark_s1;
	logic [RW-1:0]       row_s1;
	logic [MAX_COLS-1:0] rdata;
	logic [RW-1:0]       rd_addr;
	logic [SW-1:0]       run_q [MAX_COLS];
	logic [SW-1:0]       run_d [MAX_COLS];
	logic                hit;
	logic [IW-1:0]       hit_col;
	logic [SW:0]         top_w;
	logic                found_q;
	logic [RW-1:0]       top_q, end_q;
	logic [IW-1:0]       col_q;

	logic [IW+PW-1:0]    px_q;
	logic [RW+PW-1:0]    py_q;
	logic [CW+PW-1:0]    pw_q;
	logic [SW+PW-1:0]    ph_q;
	logic [31:0]         py_w, ph_w;

	logic                accept;

	assign accept    = start && (state_q == ffgp_pkg::ST_IDLE);
	assign busy      = (state_q != ffgp_pkg::ST_IDLE);
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			columns_q <= ffgp_pkg::COLUMNS_RST;
			gap_q     <= ffgp_pkg::GAP_RST;
			tw_q      <= ffgp_pkg::TOTAL_WIDTH_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				ffgp_pkg::REG_COLUMNS:     columns_q <= cfg_data[4:0];
				ffgp_pkg::REG_GAP:         gap_q     <= cfg_data[9:0];
				ffgp_pkg::REG_TOTAL_WIDTH: tw_q      <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		if (columns_q == 5'd0) begin
			cols_a = CW'(1);
		end else if (int'(columns_q) > MAX_COLS) begin
			cols_a = CW'(MAX_COLS);
		end else begin
			cols_a = CW'(columns_q);
		end
		cs_a = (col_span == 5'd0) ? CW'(1) : CW'(col_span);
		if (int'(col_span) > int'(cols_a)) begin
			cs_a = cols_a;
		end
		rs_a = (row_span == 8'd0) ? 8'd1 : row_span;
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cols_q  <= cols_a;
			cs_q    <= cs_a;
			rs_q    <= SW'(rs_a);
			tall_q  <= int'(rs_a) > ROWS;
			smask_q <= ~({MAX_COLS{1'b1}} << cs_a);
			used_q  <= UW'(cols_a - CW'(1)) * UW'(gap_q);
		end
		if (div_done) begin
			p_q <= PW'(div_quo) + PW'(gap_q);
		end
	end

	assign tw_ext   = NW'(tw_q);
	assign used_ext = NW'(used_q);
	assign numer    = (tw_ext > used_ext) ? 16'(tw_ext - used_ext) : 16'd0;

	ffgp_div #(
		.DW (16),
		.VW (CW)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (state_q == ffgp_pkg::ST_PREP),
		.num    (numer),
		.den    (cols_q),
		.done   (div_done),
		.quo    (div_quo)
	);

	always_comb begin
		mctl.clr   = accept && first_card;
		mctl.rd_en = 1'b0;
		rd_addr    = RW'(scan_addr_q);
		if (state_q == ffgp_pkg::ST_SCAN) begin
			mctl.rd_en = (int'(scan_addr_q) < ROWS);
		end else if (state_q == ffgp_pkg::ST_MARK) begin
			mctl.rd_en = (mk_left_q != '0);
			rd_addr    = mk_addr_q;
		end
		mctl.wr_en = (state_q == ffgp_pkg::ST_MARK) && vld_s1 && mark_s1;
	end

	ffgp_occ_mem #(
		.ROWS     (ROWS),
		.MAX_COLS (MAX_COLS),
		.RW       (RW)
	) u_mem (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (mctl),
		.rd_addr (rd_addr),
		.wr_addr (row_s1),
		.wr_data (rdata | wmask_q),
		.rd_data (rdata)
	);

	always_comb begin
		hit     = 1'b0;
		hit_col = '0;
		for (int c = 0; c < MAX_COLS; c++) begin
			if ((c + int'(cs_q) <= int'(cols_q)) && (((rdata >> c) & smask_q) == '0)) begin
				run_d[c] = run_q[c] + SW'(1);
			end else begin
				run_d[c] = '0;
			end
			if (!hit && (run_d[c] == rs_q) && (run_d[c] != '0)) begin
				hit     = 1'b1;
				hit_col = IW'(c);
			end
		end
		top_w = (SW+1)'(row_s1) + (SW+1)'(1) - (SW+1)'(rs_q);
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ffgp_pkg::ST_IDLE: if (start) state_d = ffgp_pkg::ST_PREP;
			ffgp_pkg::ST_PREP: state_d = ffgp_pkg::ST_DIV;
			ffgp_pkg::ST_DIV: begin
				if (div_done) state_d = tall_q ? ffgp_pkg::ST_CALC : ffgp_pkg::ST_SCAN;
			end
			ffgp_pkg::ST_SCAN: begin
				if (vld_s1 && !mark_s1) begin
					if (hit) begin
						state_d = ffgp_pkg::ST_MARK;
					end else if (int'(row_s1) == ROWS - 1) begin
						state_d = ffgp_pkg::ST_CALC;
					end
				end
			end
			ffgp_pkg::ST_MARK: begin
				if (vld_s1 && mark_s1 && (row_s1 == end_q)) state_d = ffgp_pkg::ST_CALC;
			end
			ffgp_pkg::ST_CALC: state_d = ffgp_pkg::ST_OUT;
			ffgp_pkg::ST_OUT:  state_d = ffgp_pkg::ST_IDLE;
			default:           state_d = ffgp_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ffgp_pkg::ST_IDLE;
			vld_s1  <= 1'b0;
			mark_s1 <= 1'b0;
			done    <= 1'b0;
			found_q <= 1'b0;
		end else begin
			state_q <= state_d;
			vld_s1  <= mctl.rd_en;
			mark_s1 <= (state_q == ffgp_pkg::ST_MARK);
			done    <= (state_q == ffgp_pkg::ST_OUT);
			if (accept) begin
				found_q <= 1'b0;
			end else if ((state_q == ffgp_pkg::ST_SCAN) && vld_s1 && !mark_s1 && hit) begin
				found_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (mctl.rd_en) begin
			row_s1 <= rd_addr;
		end
		if (state_q == ffgp_pkg::ST_DIV) begin
			scan_addr_q <= '0;
			for (int c = 0; c < MAX_COLS; c++) begin
				run_q[c] <= '0;
			end
		end else if (state_q == ffgp_pkg::ST_SCAN) begin
			if (mctl.rd_en) begin
				scan_addr_q <= scan_addr_q + 1'b1;
			end
			if (vld_s1 && !mark_s1) begin
				for (int c = 0; c < MAX_COLS; c++) begin
					run_q[c] <= run_d[c];
				end
				if (hit) begin
					top_q     <= RW'(top_w);
					end_q     <= row_s1;
					col_q     <= hit_col;
					wmask_q   <= smask_q << hit_col;
					mk_addr_q <= RW'(top_w);
					mk_left_q <= rs_q;
				end
			end
		end else if (state_q == ffgp_pkg::ST_MARK) begin
			if (mctl.rd_en) begin
				mk_addr_q <= mk_addr_q + 1'b1;
				mk_left_q <= mk_left_q - 1'b1;
			end
		end
		if (state_q == ffgp_pkg::ST_CALC) begin
			px_q <= IW'(col_q) * p_q;
			py_q <= RW'(top_q) * p_q;
			pw_q <= cs_q * p_q;
			ph_q <= rs_q * p_q;
		end
	end

	assign py_w = 32'(py_q);
	assign ph_w = 32'(ph_q) - 32'(gap_q);

	always_ff @(posedge clk) begin
		if (state_q == ffgp_pkg::ST_OUT) begin
			placed     <= found_q;
			grid_row   <= found_q ? 7'(top_q) : 7'd0;
			grid_col   <= found_q ? 4'(col_q) : 4'd0;
			pos_x      <= found_q ? 16'(px_q) : 16'd0;
			pos_y      <= !found_q ? 24'd0 : (py_w > ffgp_pkg::Y_MAX) ? 24'hFFFFFF : 24'(py_w);
			box_width  <= found_q ? 16'(32'(pw_q) - 32'(gap_q)) : 16'd0;
			box_height <= !found_q ? 24'd0 : (ph_w > ffgp_pkg::Y_MAX) ? 24'hFFFFFF : 24'(ph_w);
		end
	end

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n) done |-> !busy)
		else $error("result strobe while a request is still in progress");
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n) accept |=> busy)
		else $error("accepted request did not start work");
	a_write_mark: assert property (@(posedge clk) disable iff (!arst_n)
		mctl.wr_en |-> (state_q == ffgp_pkg::ST_MARK))
		else $error("occupancy written outside the marking phase");
	a_nofit_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !placed) |-> (pos_x == 16'd0 && box_height == 24'd0 && grid_row == 7'd0))
		else $error("unplaced result carries nonzero fields");

endmodule
